// File: sv/retransmit_queue_assert.svh
// assertion macros shared by the retransmit queue modules
`ifndef RETRANSMIT_QUEUE_ASSERT_SVH
`define RETRANSMIT_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define RQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("retransmit_queue: assertion failed");
`define RQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("retransmit_queue: assertion failed");
`else
`define RQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define RQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/rq_pkg.sv
package rq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam logic [31:0] RESEND_WAIT_RST = 32'd1000;

  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_ACK    = 3'd1;
  localparam logic [2:0] ACT_RESEND = 3'd2;
  localparam logic [2:0] ACT_PREV   = 3'd3;
  localparam logic [2:0] ACT_LOOKUP = 3'd4;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] payload_handle;
    logic [15:0] payload_length;
    logic [31:0] packet_id;
    logic [31:0] now;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] entry_id;
    logic [15:0] entry_handle;
    logic [15:0] entry_length;
    logic [31:0] entry_last_time;
    logic [7:0]  entry_sends;
    logic [31:0] lowest_id;
  } out_word_t;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] handle;
    logic [15:0] length;
    logic [31:0] last_time;
    logic [7:0]  sends;
  } slot_t;

  typedef struct packed {
    logic load;
    logic add;
    logic scan_start;
    logic scan_run;
    logic ack_clear;
    logic skip;
    logic resend;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       empty;
    logic       scan_done;
    logic       found;
    logic       head_settled;
    logic       out_free;
  } dp_stat_t;

endpackage

// File: sv/rq_dp.sv
`include "retransmit_queue_assert.svh"
module rq_dp #(
  parameter int QUEUE_DEPTH = rq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  rq_pkg::dp_cmd_t   cmd,
  output rq_pkg::dp_stat_t  stat,
  input  rq_pkg::in_word_t  in_data,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic              out_stall,
  output logic              out_valid,
  output rq_pkg::out_word_t out_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [IW-1:0] inc_idx(input logic [IW-1:0] x);
    inc_idx = (x == IW'(QUEUE_DEPTH - 1)) ? '0 : x + IW'(1);
  endfunction

  rq_pkg::slot_t     mem [QUEUE_DEPTH];
  rq_pkg::slot_t     rd_data;
  rq_pkg::in_word_t  item;
  rq_pkg::out_word_t res;
  rq_pkg::out_word_t res_init, out_next;
  logic [31:0]            resend_wait;
  logic [QUEUE_DEPTH-1:0] valid_bits;
  logic [IW-1:0]          head, tail, scan_addr, rd_slot, hit_slot, rd_addr;
  logic [CW-1:0]          scan_cnt, span, diff;
  logic [31:0]            next_id;
  logic                   rd_on, found, stopped;
  logic                   empty, full, issue, proc, match, find_mode, add_ok, rs_ok, due;
  logic                   mem_we;
  logic [IW-1:0]          mem_wa;
  rq_pkg::slot_t          mem_wd;
  logic [31:0]            due_time;

  assign empty = (head == tail) && !valid_bits[head];
  assign full  = (head == tail) && valid_bits[head];
  assign diff  = (tail >= head) ? CW'(tail) - CW'(head)
                                : CW'(tail) + CW'(QUEUE_DEPTH) - CW'(head);
  assign span  = empty ? '0 : ((diff == '0) ? CW'(QUEUE_DEPTH) : diff);

  assign issue     = cmd.scan_run && (scan_cnt < span);
  assign rd_addr   = cmd.scan_run ? scan_addr : head;
  assign find_mode = (item.action != rq_pkg::ACT_PREV);
  assign proc      = cmd.scan_run && rd_on && valid_bits[rd_slot] && !stopped && !found;
  assign match     = rd_data.id == item.packet_id;

  assign due_time = rd_data.last_time + resend_wait;
  assign due      = item.now > due_time;
  assign add_ok   = cmd.add && (item.payload_length != 16'd0) && !full;
  assign rs_ok    = cmd.resend && due;

  always_comb begin
    mem_we = add_ok || rs_ok;
    mem_wa = add_ok ? tail : head;
    if (add_ok) begin
      mem_wd = '{id: next_id, handle: item.payload_handle, length: item.payload_length,
                 last_time: item.now, sends: 8'd0};
    end else begin
      mem_wd = rd_data;
      mem_wd.last_time = item.now;
      mem_wd.sends = (rd_data.sends == 8'hFF) ? rd_data.sends : rd_data.sends + 8'd1;
    end
  end

  // fresh result word and the word handed out
  always_comb begin
    res_init = '0;
    res_init.status = (in_data.action > rq_pkg::ACT_LOOKUP) ? rq_pkg::ST_IGNORED
                                                            : rq_pkg::ST_MISS;
    out_next = res;
    out_next.lowest_id = empty ? next_id : rd_data.id;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      resend_wait <= rq_pkg::RESEND_WAIT_RST;
      valid_bits  <= '0;
      head        <= '0;
      tail        <= '0;
      next_id     <= '0;
      rd_on       <= 1'b0;
      found       <= 1'b0;
      stopped     <= 1'b0;
      scan_cnt    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        resend_wait <= cfg_wr_data;
      end
      if (cmd.load) begin
        found   <= 1'b0;
        stopped <= 1'b0;
      end
      if (add_ok) begin
        valid_bits[tail] <= 1'b1;
        tail    <= inc_idx(tail);
        next_id <= next_id + 32'd1;
      end
      if (cmd.scan_start) begin
        scan_cnt <= '0;
        rd_on    <= 1'b0;
      end
      if (cmd.scan_run) begin
        rd_on <= issue;
        if (issue) begin
          scan_cnt <= scan_cnt + CW'(1);
        end
        if (proc) begin
          if (find_mode && match) begin
            found <= 1'b1;
          end
          if (!find_mode && (rd_data.id >= item.packet_id)) begin
            stopped <= 1'b1;
          end
        end
      end
      if (cmd.ack_clear) begin
        valid_bits[hit_slot] <= 1'b0;
      end
      if (cmd.skip && (head != tail) && !valid_bits[head]) begin
        head <= inc_idx(head);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
      res  <= res_init;
    end
    if (cmd.add) begin
      if (item.payload_length == 16'd0) begin
        res.status <= rq_pkg::ST_IGNORED;
      end else if (full) begin
        res.status <= rq_pkg::ST_FULL;
      end else begin
        res.status          <= rq_pkg::ST_DONE;
        res.entry_id        <= next_id;
        res.entry_handle    <= item.payload_handle;
        res.entry_length    <= item.payload_length;
        res.entry_last_time <= item.now;
        res.entry_sends     <= 8'd0;
      end
    end
    if (cmd.scan_start) begin
      scan_addr <= head;
    end
    if (issue) begin
      rd_slot   <= scan_addr;
      scan_addr <= inc_idx(scan_addr);
    end
    // lookup keeps the first match, previous keeps the last id below the target
    if (proc && ((find_mode && match) || (!find_mode && (rd_data.id < item.packet_id)))) begin
      hit_slot <= rd_slot;
      if (item.action != rq_pkg::ACT_ACK) begin
        res.status          <= rq_pkg::ST_DONE;
        res.entry_id        <= rd_data.id;
        res.entry_handle    <= rd_data.handle;
        res.entry_length    <= rd_data.length;
        res.entry_last_time <= rd_data.last_time;
        res.entry_sends     <= rd_data.sends;
      end
    end
    if (cmd.ack_clear) begin
      res.status <= rq_pkg::ST_DONE;
    end
    if (rs_ok) begin
      res.status          <= rq_pkg::ST_DONE;
      res.entry_id        <= rd_data.id;
      res.entry_handle    <= rd_data.handle;
      res.entry_length    <= rd_data.length;
      res.entry_last_time <= rd_data.last_time;
      res.entry_sends     <= rd_data.sends;
    end
    if (cmd.finish) begin
      out_data <= out_next;
    end
  end

  assign stat.action       = item.action;
  assign stat.empty        = empty;
  assign stat.scan_done    = (scan_cnt == span) && !rd_on;
  assign stat.found        = found;
  assign stat.head_settled = (head == tail) || valid_bits[head];
  assign stat.out_free     = !out_valid || !out_stall;

  `RQ_ASSERT_NXT(a_add_marks_slot, clk, rst, add_ok, valid_bits[$past(tail)])
  `RQ_ASSERT_NXT(a_finish_shows_word, clk, rst, cmd.finish, out_valid)
  `RQ_ASSERT_IMP(a_no_write_in_scan, clk, rst, cmd.scan_run, !mem_we)

endmodule

// File: sv/rq_ctrl.sv
`include "retransmit_queue_assert.svh"
module rq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  rq_pkg::dp_stat_t stat,
  output rq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_ADD      = 10'b0000000100,
    S_SCAN     = 10'b0000001000,
    S_ACK      = 10'b0000010000,
    S_SKIP     = 10'b0000100000,
    S_RS_RD    = 10'b0001000000,
    S_RS_UPD   = 10'b0010000000,
    S_LOW_RD   = 10'b0100000000,
    S_DONE     = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat.action) inside
          rq_pkg::ACT_ADD: state_next = S_ADD;
          rq_pkg::ACT_ACK, rq_pkg::ACT_PREV, rq_pkg::ACT_LOOKUP: begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end
          rq_pkg::ACT_RESEND: state_next = stat.empty ? S_LOW_RD : S_RS_RD;
          default: state_next = S_LOW_RD;
        endcase
      end
      S_ADD: begin
        cmd.add = 1'b1;
        state_next = S_LOW_RD;
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = (stat.action == rq_pkg::ACT_ACK && stat.found) ? S_ACK : S_LOW_RD;
        end
      end
      S_ACK: begin
        cmd.ack_clear = 1'b1;
        state_next = S_SKIP;
      end
      S_SKIP: begin
        // head walks past freed slots one per cycle
        cmd.skip = 1'b1;
        if (stat.head_settled) begin
          state_next = S_LOW_RD;
        end
      end
      S_RS_RD:  state_next = S_RS_UPD;
      S_RS_UPD: begin
        cmd.resend = 1'b1;
        state_next = S_LOW_RD;
      end
      S_LOW_RD: state_next = S_DONE;
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `RQ_ASSERT_NXT(a_accept_dispatch, clk, rst, in_valid && !in_stall, state == S_DISPATCH)
  `RQ_ASSERT_IMP(a_finish_only_done, clk, rst, cmd.finish, state == S_DONE && stat.out_free)

endmodule

// File: sv/retransmit_queue.sv
// path, accept to word out: an add passes DISPATCH, ADD, LOW_RD and DONE; a resend poll
// DISPATCH, RS_RD, RS_UPD, LOW_RD and DONE; a resend on an empty queue or an unknown action
// goes from DISPATCH to LOW_RD; lookup, previous and ack scan the span of live ring slots,
// and a matched ack then clears its slot and walks the head past the freed slots; no new
// word is accepted until the last is handed out, and a stalled output holds that word
// reset: synchronous, empties the queue, ids restart at 0, resend_wait returns to 1000
module retransmit_queue #(
  parameter int QUEUE_DEPTH = rq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rq_pkg::in_word_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output rq_pkg::out_word_t out_data,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data
);

  rq_pkg::dp_cmd_t  cmd;
  rq_pkg::dp_stat_t stat;

  rq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_data    (out_data)
  );

endmodule
